@@ rtl/dbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbt_pkg
// Shared types, codes and constants of the dirty block tracker.
// ----------------------------------------------------------------------------
package dbt_pkg;

    localparam int TABLE_DEPTH_DEF = 16384;

    localparam int OP_W        = 2;
    localparam int BLOCK_ID_W  = 16;
    localparam int OUT_BLOCK_W = 14;

    localparam int ROW_BITS = 32;
    localparam int BIT_W    = 5;

    localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAIN = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [BLOCK_ID_W-1:0] block_id;
    } dbt_in_t;

    typedef struct packed {
        logic                   found;
        logic [OUT_BLOCK_W-1:0] out_block;
        logic                   pending;
    } dbt_out_t;

    typedef struct packed {
        logic cap_mark;
        logic cap_drain;
        logic res_plain;
        logic mem_rd;
        logic mark_wr;
        logic drain_step;
        logic clr_start;
        logic clr_step;
        logic clr_report;
    } dbt_cmd_t;

    typedef struct packed {
        logic in_range;
        logic empty;
        logic hit;
        logic last_row;
        logic clr_last;
    } dbt_status_t;

endpackage

@@ rtl/dbt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbt_ctrl
// Sequencer for mark, drain and clear beats; drives the datapath commands.
// ----------------------------------------------------------------------------
module dbt_ctrl
    import dbt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] op,
    input  dbt_status_t     st,
    output dbt_cmd_t        cmd,
    output logic            busy,
    output logic            done
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MK_RD = 3'd1;
    localparam logic [2:0] S_MK_WR = 3'd2;
    localparam logic [2:0] S_DR_RD = 3'd3;
    localparam logic [2:0] S_DR_EV = 3'd4;
    localparam logic [2:0] S_CLR   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       report_reg;
    logic       report_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        done_next   = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_MARK:
                        begin
                            if (st.in_range)
                            begin
                                cmd.cap_mark = 1'b1;
                                state_next   = S_MK_RD;
                            end
                            else
                            begin
                                cmd.res_plain = 1'b1;
                                done_next     = 1'b1;
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (!st.empty)
                            begin
                                cmd.cap_drain = 1'b1;
                                state_next    = S_DR_RD;
                            end
                            else
                            begin
                                cmd.res_plain = 1'b1;
                                done_next     = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            report_next   = 1'b1;
                            state_next    = S_CLR;
                        end
                        default:
                        begin
                            cmd.res_plain = 1'b1;
                            done_next     = 1'b1;
                        end
                    endcase
                end
            end
            S_MK_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_MK_WR;
            end
            S_MK_WR:
            begin
                cmd.mark_wr = 1'b1;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_DR_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_DR_EV;
            end
            S_DR_EV:
            begin
                cmd.drain_step = 1'b1;
                if (st.hit || st.last_row)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DR_RD;
                end
            end
            S_CLR:
            begin
                cmd.clr_step   = 1'b1;
                cmd.clr_report = report_reg;
                if (st.clr_last)
                begin
                    done_next   = report_reg;
                    report_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sweep the table after reset before taking any beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
            done_reg   <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef SYNTHESIS
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat neither in flight nor answered");

    a_mark_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MK_WR) |=> (done && !busy))
        else $error("mark write not followed by result");

    a_scan_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drain_step && !st.hit && !st.last_row) |=> (state_reg == S_DR_RD))
        else $error("drain scan did not advance to next row");
`endif

endmodule

@@ rtl/dbt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbt_datapath
// Dirty bit table in row-wide memory, pending range registers, row scan
// with first-set search, and the result register.
// ----------------------------------------------------------------------------
module dbt_datapath
    import dbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dbt_in_t     item,
    input  dbt_cmd_t    cmd,
    output dbt_status_t st,
    output dbt_out_t    result
);

    localparam int ROWS    = (TABLE_DEPTH + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W   = ROW_AW + BIT_W;
    localparam int DEPTH_W = BLOCK_ID_W + 1;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] row_q;

    logic [ROW_AW-1:0]   addr_reg;
    logic [ROW_AW-1:0]   addr_next;
    logic [IDX_W-1:0]    id_reg;
    logic [IDX_W-1:0]    id_next;
    logic [IDX_W-1:0]    low_reg;
    logic [IDX_W-1:0]    low_next;
    logic [IDX_W-1:0]    high_reg;
    logic [IDX_W-1:0]    high_next;
    logic                empty_reg;
    logic                empty_next;
    dbt_out_t            result_reg;
    dbt_out_t            result_next;

    logic [IDX_W-1:0]    item_idx;
    logic [ROW_BITS-1:0] lo_mask;
    logic [ROW_BITS-1:0] hi_mask;
    logic [ROW_BITS-1:0] masked;
    logic [BIT_W-1:0]    hit_pos;
    logic [IDX_W-1:0]    hit_idx;
    logic                hit;
    logic                last_row;
    logic                mem_we;
    logic [ROW_BITS-1:0] mem_wdata;

    assign item_idx = item.block_id[IDX_W-1:0];
    assign last_row = (addr_reg == high_reg[IDX_W-1:BIT_W]);

    always_comb
    begin
        lo_mask = {ROW_BITS{1'b1}};
        hi_mask = {ROW_BITS{1'b1}};
        if (addr_reg == low_reg[IDX_W-1:BIT_W])
        begin
            lo_mask = {ROW_BITS{1'b1}} << low_reg[BIT_W-1:0];
        end
        if (last_row)
        begin
            hi_mask = {ROW_BITS{1'b1}} >> (BIT_W'(ROW_BITS - 1) - high_reg[BIT_W-1:0]);
        end
        masked = row_q & lo_mask & hi_mask;
    end

    always_comb
    begin
        hit_pos = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                hit_pos = BIT_W'(i);
            end
        end
    end

    assign hit     = |masked;
    assign hit_idx = {addr_reg, hit_pos};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (cmd.mark_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = row_q | (ROW_BITS'(1) << id_reg[BIT_W-1:0]);
        end
        else if (cmd.drain_step && hit)
        begin
            mem_we    = 1'b1;
            mem_wdata = row_q & ~(ROW_BITS'(1) << hit_pos);
        end
        else if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            row_q <= mem[addr_reg];
        end
    end

    always_comb
    begin
        addr_next   = addr_reg;
        id_next     = id_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        empty_next  = empty_reg;
        result_next = result_reg;

        if (cmd.cap_mark)
        begin
            id_next   = item_idx;
            addr_next = item_idx[IDX_W-1:BIT_W];
        end

        if (cmd.cap_drain)
        begin
            addr_next = low_reg[IDX_W-1:BIT_W];
        end

        if (cmd.res_plain)
        begin
            result_next = '{found: 1'b0, out_block: '0, pending: !empty_reg};
        end

        if (cmd.mark_wr)
        begin
            if (empty_reg)
            begin
                low_next  = id_reg;
                high_next = id_reg;
            end
            else
            begin
                if (id_reg < low_reg)
                begin
                    low_next = id_reg;
                end
                if (id_reg > high_reg)
                begin
                    high_next = id_reg;
                end
            end
            empty_next  = 1'b0;
            result_next = '{found: 1'b0, out_block: '0, pending: 1'b1};
        end

        if (cmd.drain_step)
        begin
            if (hit)
            begin
                if (hit_idx == high_reg)
                begin
                    empty_next = 1'b1;
                end
                else
                begin
                    low_next = hit_idx + IDX_W'(1);
                end
                result_next = '{found: 1'b1, out_block: OUT_BLOCK_W'(hit_idx),
                                pending: (hit_idx != high_reg)};
            end
            else if (last_row)
            begin
                empty_next  = 1'b1;
                result_next = '{found: 1'b0, out_block: '0, pending: 1'b0};
            end
            else
            begin
                addr_next = addr_reg + ROW_AW'(1);
            end
        end

        if (cmd.clr_start)
        begin
            addr_next  = '0;
            empty_next = 1'b1;
        end

        if (cmd.clr_step)
        begin
            addr_next = addr_reg + ROW_AW'(1);
            if (cmd.clr_report)
            begin
                result_next = '{found: 1'b0, out_block: '0, pending: 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            empty_reg <= 1'b1;
            low_reg   <= '0;
            high_reg  <= '0;
        end
        else
        begin
            addr_reg  <= addr_next;
            empty_reg <= empty_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        result_reg <= result_next;
    end

    assign st.in_range = ({1'b0, item.block_id} < DEPTH_W'(TABLE_DEPTH));
    assign st.empty    = empty_reg;
    assign st.hit      = hit;
    assign st.last_row = last_row;
    assign st.clr_last = (addr_reg == ROW_AW'(ROWS - 1));

    assign result = result_reg;

`ifndef SYNTHESIS
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty_reg |-> (low_reg <= high_reg))
        else $error("pending range inverted");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_step |-> !empty_reg)
        else $error("drain scan with empty range");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drain_step && hit) |-> (hit_idx >= low_reg && hit_idx <= high_reg))
        else $error("drain hit outside pending range");
`endif

endmodule

@@ rtl/dirty_block_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_block_tracker_unit
// Dirty block table with pending range; mark, drain and clear beats.
// ----------------------------------------------------------------------------
// Usage:
//   A beat on item (op, block_id) is taken at a rising edge with start high
//   and busy low. Each beat gives one result on result, marked by done for
//   exactly one cycle; the receiver cannot hold results off.
//   Mark:  the row is read, then written, then the result is registered.
//   Drain: each 32-block table row from the low bound up to the first
//          dirty block or the high bound is read, then scanned; an empty
//          range answers in the cycle after the accept.
//   Clear: one row written per cycle over ceil(TABLE_DEPTH / 32) rows,
//          then the result is registered.
//   Other ops and out-of-range marks: result in the cycle after the accept.
//   The single-port row memory paces these steps: one read or write a cycle.
//   A new beat may be taken in the cycle its predecessor's result is shown.
//   After reset the table is swept clean, one row per cycle, with busy
//   high and no result; the range is empty.
// ----------------------------------------------------------------------------
module dirty_block_tracker_unit
    import dbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dbt_in_t  item,
    output logic     done,
    output dbt_out_t result
);

    dbt_cmd_t    cmd;
    dbt_status_t st;

    dbt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dbt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .st     (st),
        .result (result)
    );

endmodule

@@ tb/tb_dirty_block_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dirty_block_tracker_unit
// Self-checking bench for the dirty block tracker: mark, drain, clear and
// unused-op beats go in with random bursts and gaps, and a tracker model
// predicts found, out_block and pending for every beat, checked in order.
// ----------------------------------------------------------------------------
module tb_dirty_block_tracker_unit;
    import dbt_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int MAP_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int unsigned EMPTY_LOW = 32'h0000_FFFF;
    localparam int unsigned EMPTY_HIGH = 32'h0000_0000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    dbt_in_t  item = '0;
    logic     done;
    dbt_out_t result;

    bit          dirty_map [TABLE_DEPTH];
    int unsigned lo_bound;
    int unsigned hi_bound;

    dbt_out_t    want_results [$];
    int          miss_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          start_on = 1'b0;

    dirty_block_tracker_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    function automatic void empty_range();
        lo_bound = EMPTY_LOW;
        hi_bound = EMPTY_HIGH;
    endfunction

    function automatic dbt_out_t predict_tracker_result(dbt_in_t beat);
        dbt_out_t    res;
        int unsigned id;
        int unsigned cur;
        bit          hit;
        res = '0;
        id = 32'(beat.block_id);
        hit = 1'b0;
        case (beat.op)
            OP_MARK:
            begin
                if (id < TABLE_DEPTH)
                begin
                    dirty_map[MAP_AW'(id)] = 1'b1;
                    if (id < lo_bound)
                        lo_bound = id;
                    if (id > hi_bound)
                        hi_bound = id;
                end
            end
            OP_DRAIN:
            begin
                if (hi_bound >= lo_bound)
                begin
                    cur = lo_bound;
                    while (!hit && cur <= hi_bound && cur < TABLE_DEPTH)
                    begin
                        if (dirty_map[MAP_AW'(cur)])
                        begin
                            hit = 1'b1;
                            dirty_map[MAP_AW'(cur)] = 1'b0;
                            res.found = 1'b1;
                            res.out_block = OUT_BLOCK_W'(cur);
                            lo_bound = cur + 1;
                            if (lo_bound > hi_bound)
                                empty_range();
                        end
                        else
                            cur++;
                    end
                    if (!hit)
                        empty_range();
                end
            end
            OP_CLEAR:
            begin
                foreach (dirty_map[i])
                    dirty_map[i] = 1'b0;
                empty_range();
            end
            default: ;
        endcase
        res.pending = (hi_bound >= lo_bound);
        return res;
    endfunction

    task automatic log_miss(string tag, dbt_out_t want, dbt_out_t got);
        miss_count++;
        if (miss_count <= 10)
            $display("mismatch (%s): want %0d/%0d/%0d, got %0d/%0d/%0d",
                     tag, want.found, want.out_block, want.pending,
                     got.found, got.out_block, got.pending);
    endtask

    always @(posedge clk)
    begin
        dbt_out_t want;
        if (rst_n && done)
        begin
            if (want_results.size() == 0)
                log_miss("no beat waiting", '0, result);
            else
            begin
                want = want_results.pop_front();
                if (result.found !== want.found || result.out_block !== want.out_block
                    || result.pending !== want.pending)
                    log_miss("field", want, result);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic lower_start();
        if (start_on)
        begin
            start <= 1'b0;
            start_on = 1'b0;
        end
    endtask

    task automatic idle_for(int n);
        dbt_in_t junk;
        if (n == 0)
            return;
        lower_start();
        repeat (n)
        begin
            junk = dbt_in_t'($urandom);
            item <= junk;
            @(posedge clk);
        end
    endtask

    task automatic send_beat(dbt_in_t beat);
        start <= 1'b1;
        start_on = 1'b1;
        item <= beat;
        do
            @(posedge clk);
        while (busy);
        want_results.push_back(predict_tracker_result(beat));
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(1, 8);
            idle_for($urandom_range(0, 7));
        end
    endtask

    task automatic send_op(logic [OP_W-1:0] op, logic [BLOCK_ID_W-1:0] id);
        dbt_in_t beat;
        beat.op = op;
        beat.block_id = id;
        send_beat(beat);
    endtask

    task automatic hold_until_quiet();
        lower_start();
        while (want_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [BLOCK_ID_W-1:0] pick_id(int unsigned base, int unsigned span);
        int unsigned sub;
        sub = $urandom_range(0, 19);
        if (sub < 15)
            return BLOCK_ID_W'((base + $urandom_range(0, span)) % TABLE_DEPTH);
        else if (sub == 15)
            return '0;
        else if (sub == 16)
            return BLOCK_ID_W'(TABLE_DEPTH - 1);
        else if (sub == 17)
            return BLOCK_ID_W'($urandom_range(0, TABLE_DEPTH - 1));
        else
            return BLOCK_ID_W'($urandom_range(TABLE_DEPTH, 65535));
    endfunction

    function automatic dbt_in_t pick_beat(int unsigned base, int unsigned span);
        dbt_in_t     beat;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        beat.block_id = BLOCK_ID_W'($urandom);
        if (roll < 52)
        begin
            beat.op = OP_MARK;
            beat.block_id = pick_id(base, span);
        end
        else if (roll < 90)
            beat.op = OP_DRAIN;
        else if (roll < 93)
            beat.op = OP_CLEAR;
        else
            beat.op = OP_UNUSED;
        return beat;
    endfunction

    task automatic test_edges();
        send_op(OP_MARK, 16'd16383);
        send_op(OP_MARK, 16'd0);
        send_op(OP_MARK, 16'd16384);
        send_op(OP_MARK, 16'hFFFF);
        send_op(OP_MARK, 16'h8000);
        send_op(OP_DRAIN, 16'hFFFF);
        send_op(OP_DRAIN, 16'h0000);
        send_op(OP_DRAIN, 16'h5A5A);
        send_op(OP_MARK, 16'd100);
        send_op(OP_MARK, 16'd100);
        send_op(OP_UNUSED, 16'hFFFF);
        send_op(OP_DRAIN, 16'd0);
        send_op(OP_MARK, 16'd5);
        send_op(OP_MARK, 16'd7);
        send_op(OP_CLEAR, 16'hFFFF);
        send_op(OP_DRAIN, 16'd0);
        send_op(OP_MARK, 16'h2AAA);
        send_op(OP_MARK, 16'h1555);
        send_op(OP_UNUSED, 16'h0000);
        send_op(OP_DRAIN, 16'd0);
        send_op(OP_DRAIN, 16'd0);
        send_op(OP_DRAIN, 16'd0);
        send_op(OP_MARK, 16'h4000);
        send_op(OP_CLEAR, 16'h0000);
        hold_until_quiet();
    endtask

    task automatic test_drain_runs();
        int unsigned base;
        int unsigned span;
        int          k;
        for (int round = 0; round < 14; round++)
        begin
            base = $urandom_range(0, TABLE_DEPTH - 1);
            span = (round % 4 == 3) ? 2000 : 40;
            k = $urandom_range(1, 10);
            for (int j = 0; j < k; j++)
                send_op(OP_MARK, pick_id(base, span));
            for (int j = 0; j <= k; j++)
                send_op(OP_DRAIN, BLOCK_ID_W'($urandom));
            if (round % 3 == 0)
                hold_until_quiet();
        end
    endtask

    task automatic test_random_mix();
        int unsigned base;
        int unsigned span;
        base = 0;
        span = 0;
        for (int n = 0; n < 480; n++)
        begin
            if (n % 40 == 0)
            begin
                base = $urandom_range(0, TABLE_DEPTH - 1);
                span = ($urandom_range(0, 3) == 0) ? 600 : $urandom_range(0, 63);
            end
            send_beat(pick_beat(base, span));
            if (n == 240)
                hold_until_quiet();
        end
    endtask

    initial
    begin
        empty_range();
        burst_left = $urandom_range(1, 8);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_edges();
        test_drain_runs();
        test_random_mix();
        hold_until_quiet();
        repeat (32) @(posedge clk);
        if (miss_count == 0 && want_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
